### src/wsd_pkg.sv
// Shared types, constants and register codes for the LED chain driver.
package wsd_pkg;

    // Default pixel store depth
    localparam int unsigned MAX_LEDS_DEF = 256;

    // Configuration port geometry
    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_NUM_LEDS   = 3'd0;
    localparam logic [2:0] REG_ZERO_HIGH  = 3'd1;
    localparam logic [2:0] REG_ONE_HIGH   = 3'd2;
    localparam logic [2:0] REG_BIT_PERIOD = 3'd3;
    localparam logic [2:0] REG_LATCH      = 3'd4;

    // Register reset values
    localparam logic [8:0]  RST_NUM_LEDS   = 9'd0;
    localparam logic [9:0]  RST_ZERO_HIGH  = 10'd30;
    localparam logic [9:0]  RST_ONE_HIGH   = 10'd60;
    localparam logic [9:0]  RST_BIT_PERIOD = 10'd105;
    localparam logic [15:0] RST_LATCH      = 16'd5000;

    // Item action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_SHOW  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // Green-red-blue pixel word
    typedef logic [23:0] t_pixel;

    // Configuration register file contents
    typedef struct packed {
        logic [8:0]  num_leds;
        logic [9:0]  zero_high_ticks;
        logic [9:0]  one_high_ticks;
        logic [9:0]  bit_period_ticks;
        logic [15:0] latch_ticks;
    } t_cfg;

    // Controller to waveform engine
    typedef struct packed {
        logic step;   // one tick item accepted
        logic start;  // begin a frame
    } t_wave_ctl;

    // Waveform engine to controller
    typedef struct packed {
        logic busy;      // frame or latch gap in progress now
        logic nxt_busy;  // busy after this cycle's step/start
        logic nxt_line;  // line level after this cycle's step/start
    } t_wave_sts;

endpackage

### src/wsd_if.sv
// Item channel interfaces: command input and per-item result output.
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, action, led_index, red, green, blue, input ready);
    modport sink   (input valid, action, led_index, red, green, blue, output ready);
endinterface

interface wsd_out_if;
    logic valid;
    logic ready;
    logic data_line;
    logic busy_res;
    logic rejected;

    modport source (output valid, data_line, busy_res, rejected, input ready);
    modport sink   (input valid, data_line, busy_res, rejected, output ready);
endinterface

### src/wsd_pix_mem.sv
// Pixel store: one write port, one read port with registered read data.
module wsd_pix_mem #(
    parameter int unsigned MAX_LEDS = wsd_pkg::MAX_LEDS_DEF,
    localparam int unsigned AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_wr_en,
    input  logic [AW-1:0]          i_wr_addr,
    input  wsd_pkg::t_pixel        i_wr_data,
    input  logic [AW-1:0]          i_rd_addr,
    output wsd_pkg::t_pixel        o_rd_data
);
    wsd_pkg::t_pixel r_mem [MAX_LEDS];
    wsd_pkg::t_pixel r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

### src/wsd_cfg_regs.sv
// APB-style configuration register file.
module wsd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsd_pkg::PADDR_W-1:0]   paddr,
    input  logic [wsd_pkg::PDATA_W-1:0]   pwdata,
    output logic [wsd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output wsd_pkg::t_cfg                 o_cfg
);
    wsd_pkg::t_cfg r_cfg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_leds         <= wsd_pkg::RST_NUM_LEDS;
            r_cfg.zero_high_ticks  <= wsd_pkg::RST_ZERO_HIGH;
            r_cfg.one_high_ticks   <= wsd_pkg::RST_ONE_HIGH;
            r_cfg.bit_period_ticks <= wsd_pkg::RST_BIT_PERIOD;
            r_cfg.latch_ticks      <= wsd_pkg::RST_LATCH;
        end else if (wr_en) begin
            unique case (reg_idx)
                wsd_pkg::REG_NUM_LEDS:   r_cfg.num_leds         <= pwdata[8:0];
                wsd_pkg::REG_ZERO_HIGH:  r_cfg.zero_high_ticks  <= pwdata[9:0];
                wsd_pkg::REG_ONE_HIGH:   r_cfg.one_high_ticks   <= pwdata[9:0];
                wsd_pkg::REG_BIT_PERIOD: r_cfg.bit_period_ticks <= pwdata[9:0];
                wsd_pkg::REG_LATCH:      r_cfg.latch_ticks      <= pwdata[15:0];
                default: ;  // unmapped, ignored
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            wsd_pkg::REG_NUM_LEDS:   prdata = {23'd0, r_cfg.num_leds};
            wsd_pkg::REG_ZERO_HIGH:  prdata = {22'd0, r_cfg.zero_high_ticks};
            wsd_pkg::REG_ONE_HIGH:   prdata = {22'd0, r_cfg.one_high_ticks};
            wsd_pkg::REG_BIT_PERIOD: prdata = {22'd0, r_cfg.bit_period_ticks};
            wsd_pkg::REG_LATCH:      prdata = {16'd0, r_cfg.latch_ticks};
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

### src/wsd_wave.sv
// Waveform engine: frame/bit/tick counters and line level.
module wsd_wave #(
    parameter int unsigned MAX_LEDS = wsd_pkg::MAX_LEDS_DEF,
    localparam int unsigned AW  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1,
    localparam int unsigned CWN = $clog2(MAX_LEDS + 1),
    localparam int unsigned CW  = (CWN > 9) ? CWN : 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wsd_pkg::t_wave_ctl   i_ctl,
    input  wsd_pkg::t_cfg        i_cfg,
    input  logic [CW-1:0]        i_active,
    input  wsd_pkg::t_pixel      i_word,
    output logic [AW-1:0]        o_rd_addr,
    output wsd_pkg::t_wave_sts   o_sts
);
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_SEND  = 3'b010,
        PH_LATCH = 3'b100
    } t_phase;

    t_phase         r_phase, n_phase;
    logic [CW-1:0]  r_led,   n_led;
    logic [4:0]     r_bit,   n_bit;
    logic [15:0]    r_tick,  n_tick;
    logic           r_line,  n_line;

    logic [15:0]    tick_p1;
    logic           bit_val;
    logic [9:0]     high_ticks;
    logic [9:0]     period;
    logic [CW-1:0]  led_p1;
    t_phase         latch_phase;

    assign tick_p1     = r_tick + 16'd1;
    assign bit_val     = i_word[5'd23 - r_bit];
    assign high_ticks  = bit_val ? i_cfg.one_high_ticks : i_cfg.zero_high_ticks;
    assign period      = (i_cfg.bit_period_ticks == 10'd0) ? 10'd1 : i_cfg.bit_period_ticks;
    assign led_p1      = r_led + CW'(1);
    assign latch_phase = (i_cfg.latch_ticks == 16'd0) ? PH_IDLE : PH_LATCH;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_led   = r_led;
        n_bit   = r_bit;
        n_tick  = r_tick;
        n_line  = r_line;
        if (i_ctl.start) begin
            n_led  = '0;
            n_bit  = '0;
            n_tick = '0;
            n_line = 1'b0;
            n_phase = (i_active == '0) ? latch_phase : PH_SEND;
        end else if (i_ctl.step) begin
            unique case (r_phase)
                PH_SEND: begin
                    n_line = (r_tick < {6'd0, high_ticks});
                    n_tick = tick_p1;
                    if (tick_p1 >= {6'd0, period}) begin
                        n_tick = '0;
                        if (r_bit >= 5'd23) begin
                            n_bit = '0;
                            n_led = led_p1;
                            if (led_p1 >= i_active) begin
                                n_line  = 1'b0;
                                n_phase = latch_phase;
                            end
                        end else begin
                            n_bit = r_bit + 5'd1;
                        end
                    end
                end
                PH_LATCH: begin
                    n_line = 1'b0;
                    n_tick = tick_p1;
                    if (tick_p1 >= i_cfg.latch_ticks) begin
                        n_tick  = '0;
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_line = 1'b0;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_led   <= '0;
            r_bit   <= '0;
            r_tick  <= '0;
            r_line  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_led   <= n_led;
            r_bit   <= n_bit;
            r_tick  <= n_tick;
            r_line  <= n_line;
        end
    end

    // read address follows the next LED so read data tracks the current LED
    assign o_rd_addr      = n_led[AW-1:0];
    assign o_sts.busy     = (r_phase != PH_IDLE);
    assign o_sts.nxt_busy = (n_phase != PH_IDLE);
    assign o_sts.nxt_line = n_line;
endmodule

### src/ws2812_led_chain_driver_top.sv
// Top level of the LED chain driver: item handshake, store sweeps, result register.
//
//  channel  | dir | handshake          | payload
//  i_in     | in  | valid/ready        | action, led_index, red, green, blue
//  o_out    | out | valid/ready        | data_line, busy_res, rejected
//  cfg      | in  | psel/penable/pready| paddr, pwdata, prdata
//
// Tick, set pixel, show and rejected items are taken one per cycle while the
// result slot is free. Clear and show runs the accept, one store entry zeroed a
// cycle, an end check, then the frame start once the result slot is free; no item
// is taken meanwhile. After reset the store is zeroed before the first item.
// Input ready drops while the result register is full and not being taken.
module ws2812_led_chain_driver_top #(
    parameter int unsigned MAX_LEDS = wsd_pkg::MAX_LEDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    wsd_in_if.sink                        i_in,
    wsd_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsd_pkg::PADDR_W-1:0]   paddr,
    input  logic [wsd_pkg::PDATA_W-1:0]   pwdata,
    output logic [wsd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    localparam int unsigned AW  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int unsigned CWN = $clog2(MAX_LEDS + 1);
    localparam int unsigned CW  = (CWN > 9) ? CWN : 9;

    typedef enum logic [3:0] {
        ST_INIT  = 4'b0001,  // zeroing store after reset
        ST_RUN   = 4'b0010,  // taking items
        ST_CLEAR = 4'b0100,  // zeroing shown entries
        ST_SHOW  = 4'b1000   // start frame after clear
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_sweep, n_sweep;
    logic                r_out_valid, n_out_valid;
    logic                r_out_line, n_out_line;
    logic                r_out_busy, n_out_busy;
    logic                r_out_rej, n_out_rej;

    wsd_pkg::t_cfg       cfg;
    wsd_pkg::t_wave_ctl  wave_ctl;
    wsd_pkg::t_wave_sts  wave_sts;
    wsd_pkg::t_pixel     rd_word;
    wsd_pkg::t_pixel     wr_data;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic                wr_en;
    logic [CW-1:0]       active;
    logic                out_free;
    logic                in_acc;

    // configuration registers
    wsd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // pixel store
    wsd_pix_mem #(.MAX_LEDS(MAX_LEDS)) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_word)
    );

    // waveform engine
    wsd_wave #(.MAX_LEDS(MAX_LEDS)) u_wave (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (wave_ctl),
        .i_cfg     (cfg),
        .i_active  (active),
        .i_word    (rd_word),
        .o_rd_addr (rd_addr),
        .o_sts     (wave_sts)
    );

    // LEDs in use, clamped to store depth
    assign active = (CW'(cfg.num_leds) > CW'(MAX_LEDS)) ? CW'(MAX_LEDS) : CW'(cfg.num_leds);

    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == ST_RUN) && out_free;
    assign in_acc      = i_in.valid && i_in.ready;

    // control, store writes and result capture
    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_line  = r_out_line;
        n_out_busy  = r_out_busy;
        n_out_rej   = r_out_rej;
        wave_ctl    = '0;
        wr_en       = 1'b0;
        wr_addr     = r_sweep[AW-1:0];
        wr_data     = '0;
        unique case (r_state)
            ST_INIT: begin
                wr_en = 1'b1;
                n_sweep = r_sweep + CW'(1);
                if (r_sweep == CW'(MAX_LEDS - 1)) begin
                    n_sweep = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (in_acc) begin
                    n_out_valid = 1'b1;
                    n_out_rej   = 1'b0;
                    if (i_in.action == wsd_pkg::ACT_TICK) begin
                        wave_ctl.step = 1'b1;
                    end else if (wave_sts.busy) begin
                        n_out_rej = 1'b1;
                    end else begin
                        unique case (i_in.action)
                            wsd_pkg::ACT_SET: begin
                                wr_addr = AW'(i_in.led_index);
                                wr_data = {i_in.green, i_in.red, i_in.blue};
                                if (CW'(i_in.led_index) < active) begin
                                    wr_en = 1'b1;
                                end else begin
                                    n_out_rej = 1'b1;
                                end
                            end
                            wsd_pkg::ACT_SHOW: begin
                                wave_ctl.start = 1'b1;
                            end
                            default: begin
                                // clear: result waits for the sweep
                                n_out_valid = 1'b0;
                                n_sweep     = '0;
                                n_state     = ST_CLEAR;
                            end
                        endcase
                    end
                    n_out_line = wave_sts.nxt_line;
                    n_out_busy = wave_sts.nxt_busy;
                end
            end
            ST_CLEAR: begin
                if (r_sweep == active) begin
                    n_state = ST_SHOW;
                end else begin
                    wr_en   = 1'b1;
                    n_sweep = r_sweep + CW'(1);
                end
            end
            default: begin
                // ST_SHOW: start frame once the result slot is free
                if (out_free) begin
                    wave_ctl.start = 1'b1;
                    n_out_valid    = 1'b1;
                    n_out_line     = wave_sts.nxt_line;
                    n_out_busy     = wave_sts.nxt_busy;
                    n_out_rej      = 1'b0;
                    n_state        = ST_RUN;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_line <= n_out_line;
        r_out_busy <= n_out_busy;
        r_out_rej  <= n_out_rej;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.data_line = r_out_line;
    assign o_out.busy_res  = r_out_busy;
    assign o_out.rejected  = r_out_rej;
endmodule
